[rtl/hbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants of the bilinear hypercolumn sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

   localparam int STORE_DEPTH_DEFAULT  = 65536;
   localparam int MAX_CHANNELS_DEFAULT = 64;

   localparam int VALUE_W  = 16;   // signed Q8.8 feature word
   localparam int ADDR_W   = 16;   // load address field
   localparam int POS_W    = 12;   // full-resolution coordinate
   localparam int SIZE_W   = 11;   // level width / height
   localparam int SCALE_W  = 7;    // scale factor and channel count
   localparam int CHIDX_W  = 6;    // channel index field
   localparam int WEIGHT_W = 16;   // weight fraction bits
   localparam int CSR_W    = 11;   // widest register
   localparam int DIV_STEPS = 16;  // quotient bits per divider pass

   typedef enum logic [1:0] {
      CSR_LEVEL_WIDTH   = 2'd0,
      CSR_LEVEL_HEIGHT  = 2'd1,
      CSR_SCALE_FACTOR  = 2'd2,
      CSR_CHANNEL_COUNT = 2'd3
   } csr_index_type;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic [ADDR_W-1:0]         load_address;
      logic signed [VALUE_W-1:0] load_value;
      logic [POS_W-1:0]          point_row;
      logic [POS_W-1:0]          point_col;
   } req_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sample_value;
      logic [CHIDX_W-1:0]        channel_index;
      logic                      last;
   } rsp_item_type;

   typedef struct packed {
      logic start;   // load numerator, begin coordinate division
      logic wstart;  // keep quotient, begin weight division
      logic step;    // one restoring division step
   } axis_cmd_type;

   typedef struct packed {
      logic         load_we;
      axis_cmd_type axis;
      logic         map;    // register corners, weights and row offsets
      logic         issue;  // send one channel into the pipeline
   } ctrl_cmd_type;

   typedef struct packed {
      logic adv;         // pipeline may advance this cycle
      logic issue_last;  // channel being issued is the final one
      logic pipe_busy;   // items in flight ahead of the output register
   } ctrl_status_type;

endpackage

[rtl/hbs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hbs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[rtl/hbs_axis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_axis
// One coordinate axis: serial divide of (2*pos+1-s) by 2s, then serial
// weight divide, then floor/ceil clamping against the level size.
// ----------------------------------------------------------------------------
module hbs_axis import hbs_pkg::*; (
   input  logic                clock,
   input  axis_cmd_type        cmd,
   input  logic [POS_W-1:0]    pos,
   input  logic [SCALE_W-1:0]  scale,
   input  logic [SIZE_W-1:0]   size,
   output logic [SIZE_W-1:0]   lo,
   output logic [SIZE_W-1:0]   hi,
   output logic [WEIGHT_W-1:0] weight
);
   localparam int NUM_W = POS_W + 2;

   // remainder spans the full divisor range, up to 2s-1
   logic [DIV_STEPS-1:0] dvd_ff, dvd_in;
   logic [SCALE_W:0]     rem_ff, rem_in;
   logic                 neg_ff, neg_in;
   logic [NUM_W-2:0]     q_ff, q_in;
   logic                 rnz_ff, rnz_in;

   logic [NUM_W-1:0]   num;
   logic [SCALE_W:0]   dvs;
   logic [SCALE_W+1:0] trial;
   logic               ge;
   logic [SIZE_W-1:0]  size_m1;
   logic [NUM_W-1:0]   ceil_q;
   logic [SIZE_W-1:0]  f_idx;
   logic [SIZE_W-1:0]  c_idx;

   assign num = NUM_W'({1'b0, pos, 1'b1}) - NUM_W'(scale);
   assign dvs = {scale, 1'b0};
   assign trial = {rem_ff, dvd_ff[DIV_STEPS-1]};
   assign ge = (trial >= (SCALE_W+2)'(dvs));

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      q_in   = q_ff;
      rnz_in = rnz_ff;
      priority if (cmd.start) begin
         dvd_in = DIV_STEPS'(num[NUM_W-2:0]);
         rem_in = '0;
         neg_in = num[NUM_W-1];
      end else if (cmd.wstart) begin
         q_in   = dvd_ff[NUM_W-2:0];
         rnz_in = (rem_ff != '0);
         dvd_in = DIV_STEPS'(scale);
      end else if (cmd.step) begin
         rem_in = ge ? (SCALE_W+1)'(trial - (SCALE_W+2)'(dvs)) : trial[SCALE_W:0];
         dvd_in = {dvd_ff[DIV_STEPS-2:0], ge};
      end else begin
         // hold
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
      rnz_ff <= rnz_in;
   end

   // Clamp floor at size-1, collapse ceil onto floor past the edge.
   assign size_m1 = size - 1'b1;
   assign ceil_q  = NUM_W'(q_ff) + NUM_W'(rnz_ff);
   assign f_idx   = (q_ff > (NUM_W-1)'(size_m1)) ? size_m1 : SIZE_W'(q_ff);
   assign c_idx   = (ceil_q < NUM_W'(size)) ? SIZE_W'(ceil_q) : f_idx;

   assign lo     = neg_ff ? '0 : f_idx;
   assign hi     = neg_ff ? '0 : c_idx;
   assign weight = (lo == hi) ? '0 : dvd_ff;
endmodule

[rtl/hbs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_ctrl
// Sequencer: loads, the two divider passes, mapping, channel issue, drain.
// ----------------------------------------------------------------------------
module hbs_ctrl import hbs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_kind,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIV   = 7'b0000010,
      ST_SETW  = 7'b0000100,
      ST_WGT   = 7'b0001000,
      ST_MAP   = 7'b0010000,
      ST_RUN   = 7'b0100000,
      ST_DRAIN = 7'b1000000
   } state_type;

   localparam int CNT_W = $clog2(DIV_STEPS);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == KIND_QUERY) begin
                  cmd.axis.start = 1'b1;
                  cnt_in         = '0;
                  state_in       = ST_DIV;
               end else begin
                  cmd.load_we = 1'b1;
               end
            end
         end
         ST_DIV: begin
            cmd.axis.step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_SETW;
            end
         end
         ST_SETW: begin
            cmd.axis.wstart = 1'b1;
            cnt_in          = '0;
            state_in        = ST_WGT;
         end
         ST_WGT: begin
            cmd.axis.step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.map  = 1'b1;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.adv) begin
               cmd.issue = 1'b1;
               if (status.issue_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule

[rtl/hbs_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_datapath
// Registers, four replicated feature stores, axis mappers and blend pipeline.
// ----------------------------------------------------------------------------
module hbs_datapath import hbs_pkg::*; #(
   parameter int STORE_DEPTH  = STORE_DEPTH_DEFAULT,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  csr_index_type   csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  req_item_type    req_item,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_item_type    rsp_item
);
   localparam int AW    = $clog2(STORE_DEPTH);
   localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ROW_W = 2 * SIZE_W;
   localparam int WB_W  = WEIGHT_W + 1;
   localparam int P_W   = VALUE_W + WB_W;
   localparam int T_W   = VALUE_W + WEIGHT_W;
   localparam int Q_W   = T_W + WB_W;
   localparam int S_W   = VALUE_W + 2 * WEIGHT_W;
   localparam logic [VALUE_W-1:0] SIGN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [WB_W-1:0]    ONE  = {1'b1, {WEIGHT_W{1'b0}}};

   // Configuration registers
   logic [SIZE_W-1:0]  lw_ff, lh_ff;
   logic [SCALE_W-1:0] sf_ff, cc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff <= SIZE_W'(1);
         lh_ff <= SIZE_W'(1);
         sf_ff <= SCALE_W'(1);
         cc_ff <= SCALE_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LEVEL_WIDTH:   lw_ff <= csr_wdata[SIZE_W-1:0];
            CSR_LEVEL_HEIGHT:  lh_ff <= csr_wdata[SIZE_W-1:0];
            CSR_SCALE_FACTOR:  sf_ff <= csr_wdata[SCALE_W-1:0];
            CSR_CHANNEL_COUNT: cc_ff <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   logic [SIZE_W-1:0]  wdt, hgt;
   logic [SCALE_W-1:0] scl;
   logic [CW-1:0]      ch_last;

   assign wdt = (lw_ff == '0) ? SIZE_W'(1) : lw_ff;
   assign hgt = (lh_ff == '0) ? SIZE_W'(1) : lh_ff;
   assign scl = (sf_ff == '0) ? SCALE_W'(1) : sf_ff;
   always_comb begin
      if (cc_ff == '0) begin
         ch_last = '0;
      end else if (cc_ff > SCALE_W'(MAX_CHANNELS)) begin
         ch_last = CW'(MAX_CHANNELS - 1);
      end else begin
         ch_last = CW'(cc_ff - 1'b1);
      end
   end

   // Axis mappers
   logic [SIZE_W-1:0]   fx, cx, fy, cy;
   logic [WEIGHT_W-1:0] wx, wy;

   hbs_axis u_axis_x (
      .clock (clock), .cmd (cmd.axis), .pos (req_item.point_col), .scale (scl),
      .size (wdt), .lo (fx), .hi (cx), .weight (wx)
   );
   hbs_axis u_axis_y (
      .clock (clock), .cmd (cmd.axis), .pos (req_item.point_row), .scale (scl),
      .size (hgt), .lo (fy), .hi (cy), .weight (wy)
   );

   // Mapped query
   logic [SIZE_W-1:0] fx_ff, cx_ff;
   logic [ROW_W-1:0]  rowf_ff, rowc_ff, plane_ff;
   logic [WB_W-1:0]   wx_ff, wxb_ff, wy_ff, wyb_ff;
   logic [CW-1:0]     last_ff, ch_ff;
   logic [AW-1:0]     base_ff;

   always_ff @(posedge clock) begin
      if (cmd.map) begin
         fx_ff    <= fx;
         cx_ff    <= cx;
         rowf_ff  <= ROW_W'(fy) * ROW_W'(wdt);
         rowc_ff  <= ROW_W'(cy) * ROW_W'(wdt);
         plane_ff <= ROW_W'(wdt) * ROW_W'(hgt);
         wx_ff    <= WB_W'(wx);
         wxb_ff   <= ONE - WB_W'(wx);
         wy_ff    <= WB_W'(wy);
         wyb_ff   <= ONE - WB_W'(wy);
         last_ff  <= ch_last;
         ch_ff    <= '0;
         base_ff  <= '0;
      end else if (cmd.issue) begin
         ch_ff    <= ch_ff + 1'b1;
         base_ff  <= base_ff + AW'(plane_ff);
      end
   end

   // Stores: four copies so all corners read in the same cycle
   logic              adv;
   logic [AW-1:0]     raddr [4];
   logic [VALUE_W-1:0] rdata [4];

   assign raddr[0] = base_ff + AW'(rowf_ff) + AW'(fx_ff);
   assign raddr[1] = base_ff + AW'(rowf_ff) + AW'(cx_ff);
   assign raddr[2] = base_ff + AW'(rowc_ff) + AW'(fx_ff);
   assign raddr[3] = base_ff + AW'(rowc_ff) + AW'(cx_ff);

   for (genvar k = 0; k < 4; k++) begin : g_bank
      hbs_ram #(.WIDTH (VALUE_W), .DEPTH (STORE_DEPTH)) u_ram (
         .clock (clock),
         .we    (cmd.load_we),
         .waddr (AW'(req_item.load_address)),
         .wdata (req_item.load_value),
         .re    (adv),
         .raddr (raddr[k]),
         .rdata (rdata[k])
      );
   end

   // Blend pipeline: read, horizontal products, vertical products, round
   logic               v1_ff, v2_ff, v3_ff, ov_ff;
   logic [CW-1:0]      ch1_ff, ch2_ff, ch3_ff;
   logic               l1_ff, l2_ff, l3_ff;
   logic [P_W-1:0]     p0_ff, p1_ff, p2_ff, p3_ff;
   logic [Q_W-1:0]     q0_ff, q1_ff;
   rsp_item_type       out_ff;
   logic [T_W-1:0]     top, bot;
   logic [S_W-1:0]     sum;
   logic [VALUE_W-1:0] b0, b1, b2, b3;

   assign adv = !ov_ff || rsp_ready;
   assign b0  = rdata[0] ^ SIGN;
   assign b1  = rdata[1] ^ SIGN;
   assign b2  = rdata[2] ^ SIGN;
   assign b3  = rdata[3] ^ SIGN;
   assign top = T_W'(p0_ff + p1_ff);
   assign bot = T_W'(p2_ff + p3_ff);
   assign sum = S_W'(q0_ff + q1_ff + (Q_W'(1) << (2 * WEIGHT_W - 1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         ov_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ch1_ff <= ch_ff;
         l1_ff  <= (ch_ff == last_ff);
         ch2_ff <= ch1_ff;
         l2_ff  <= l1_ff;
         p0_ff  <= P_W'(b0) * P_W'(wxb_ff);
         p1_ff  <= P_W'(b1) * P_W'(wx_ff);
         p2_ff  <= P_W'(b2) * P_W'(wxb_ff);
         p3_ff  <= P_W'(b3) * P_W'(wx_ff);
         ch3_ff <= ch2_ff;
         l3_ff  <= l2_ff;
         q0_ff  <= Q_W'(top) * Q_W'(wyb_ff);
         q1_ff  <= Q_W'(bot) * Q_W'(wy_ff);
         out_ff.sample_value  <= sum[S_W-1:2*WEIGHT_W] ^ SIGN;
         out_ff.channel_index <= CHIDX_W'(ch3_ff);
         out_ff.last          <= l3_ff;
      end
   end

   assign rsp_valid         = ov_ff;
   assign rsp_item          = out_ff;
   assign status.adv        = adv;
   assign status.issue_last = (ch_ff == last_ff);
   assign status.pipe_busy  = v1_ff || v2_ff || v3_ff;
endmodule

[rtl/hypercolumn_bilinear_sampler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hypercolumn_bilinear_sampler_unit
// Bilinear gather of one channel-major feature level at full-resolution points.
// ----------------------------------------------------------------------------
// Load item: one per cycle while idle.
// Query item: accept, coordinate divide, weight divide setup, weight divide and map,
//   then one channel per cycle while the output is not stalled, the first result
//   leaving through the read, horizontal, vertical and round registers; the serial
//   dividers and the blend pipeline, fed by four store copies, set the query pace.
// Reset: registers return to 1, pipeline empties; the store is not cleared.
// ----------------------------------------------------------------------------
module hypercolumn_bilinear_sampler_unit import hbs_pkg::*; #(
   parameter int STORE_DEPTH  = STORE_DEPTH_DEFAULT,   // power of two
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  csr_index_type    csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_item_type     req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_item_type     rsp_item
);
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Sequencer: accepts an item only when no channel is ahead of the output register
   hbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_item.kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: stores, axis dividers, blend pipeline and output register
   hbs_datapath #(
      .STORE_DEPTH  (STORE_DEPTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // An item is taken only with no channel ahead of the output register
   a_accept_empty: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !status.pipe_busy)
      else $error("item accepted with channels in flight");

   // A query holds off the next item for the divide passes
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_item.kind == KIND_QUERY) |=> !req_ready)
      else $error("item accepted during query");

   // Store writes happen only on accepted load items
   a_load_write: assert property (@(posedge clock) disable iff (reset)
      cmd.load_we |-> req_valid && req_ready && (req_item.kind == KIND_LOAD))
      else $error("store write without load item");

   // Channels are issued only when the pipeline can advance
   a_issue_adv: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> status.adv && !req_ready)
      else $error("channel issued while stalled");
endmodule
